>>> rtl/core/crde_pkg.sv
package crde_pkg;

	// default geometry of the frame store
	localparam int MAX_WIDTH_DEF  = 64;
	localparam int MAX_HEIGHT_DEF = 64;

	// fixed by the 4096-entry store and the field widths
	localparam int STORE_DEPTH = 4096;
	localparam int ADDR_W      = 12;
	localparam int COORD_W     = 7;
	localparam int POS_W       = 8;
	localparam int SPAN_W      = 9;
	localparam int PIX_W       = 8;
	localparam int SIZE_W      = 7;
	localparam int RADIUS_W    = 11;
	localparam int R2_W        = 14;
	localparam int SQ_W        = 16;
	localparam int CFG_IDX_W   = 2;
	localparam int CFG_DATA_W  = 8;

	typedef enum logic [2:0] {
		OP_FILL       = 3'd0,
		OP_SET        = 3'd1,
		OP_GET        = 3'd2,
		OP_HLINE      = 3'd3,
		OP_VLINE      = 3'd4,
		OP_BOX        = 3'd5,
		OP_FILLED_BOX = 3'd6,
		OP_DISK       = 3'd7
	} op_t;

	typedef enum logic [CFG_IDX_W-1:0] {
		REG_ACTIVE_WIDTH  = 2'd0,
		REG_ACTIVE_HEIGHT = 2'd1,
		REG_BACKGROUND    = 2'd2
	} reg_idx_t;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_SETUP,
		ST_SCAN,
		ST_DRAIN,
		ST_GET_READ
	} state_t;

	// outlined box is drawn one side at a time
	typedef enum logic [1:0] {
		SIDE_TOP    = 2'd0,
		SIDE_BOTTOM = 2'd1,
		SIDE_LEFT   = 2'd2,
		SIDE_RIGHT  = 2'd3
	} box_side_t;

endpackage

>>> rtl/core/crde_ram.sv
module crde_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 4096
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] wr_addr,
	input  logic [WIDTH-1:0]         wr_data,
	input  logic                     rd_en,
	input  logic [$clog2(DEPTH)-1:0] rd_addr,
	output logic [WIDTH-1:0]         rd_data
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[wr_addr] <= wr_data;
		end
		if (rd_en) begin
			rd_data <= mem[rd_addr];
		end
	end

endmodule

>>> rtl/core/char_raster_draw_engine.sv
// Character raster drawing engine: a byte frame store of MAX_WIDTH x MAX_HEIGHT
// pixels (entry y*MAX_WIDTH+x of a 4096-byte RAM) driven by drawing commands.
// Command channel: a command word is taken at a clock edge where start is high
// and busy is low; busy then stays high until the command has finished.
// Result channel: done is high for exactly one cycle per command, with
// read_value and out_of_bounds valid in that cycle. The receiver cannot stall.
// Config port: cfg_write/cfg_index/cfg_data; the user writes it only while busy
// is low, which the engine itself does not enforce.
// Command sequence from accept to done:
//   set, get        : a drain state (set) or a read state (get), then done.
//   lines and boxes : a setup state per rectangle (one per side for an outlined
//                     box), a scan over every clipped pixel of it, then a drain
//                     state and done.
//   fill, disk      : setup, a scan of the whole w x h saturated active area,
//                     a drain state and done; the disk writes only the pixels
//                     inside the circle.
// The rate is set by the single RAM write port: one pixel per clock.
// Reset clears the control state and config (64 x 64, background 0); the
// frame store is not cleared and must be filled by software before reads.
module char_raster_draw_engine #(
	parameter int MAX_WIDTH  = crde_pkg::MAX_WIDTH_DEF,
	parameter int MAX_HEIGHT = crde_pkg::MAX_HEIGHT_DEF
) (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            start,
	output logic                            busy,
	input  logic [2:0]                      operation,
	input  logic signed [crde_pkg::POS_W-1:0] x_a,
	input  logic signed [crde_pkg::POS_W-1:0] y_a,
	input  logic signed [crde_pkg::POS_W-1:0] x_b,
	input  logic signed [crde_pkg::POS_W-1:0] y_b,
	input  logic [crde_pkg::PIX_W-1:0]      pixel_value,
	input  logic [crde_pkg::RADIUS_W-1:0]   radius_q4,
	input  logic                            cfg_write,
	input  logic [crde_pkg::CFG_IDX_W-1:0]  cfg_index,
	input  logic [crde_pkg::CFG_DATA_W-1:0] cfg_data,
	output logic                            done,
	output logic [crde_pkg::PIX_W-1:0]      read_value,
	output logic                            out_of_bounds
);

	import crde_pkg::*;

	// ---- configuration registers
	logic [SIZE_W-1:0] active_width_q;
	logic [SIZE_W-1:0] active_height_q;
	logic [PIX_W-1:0]  background_q;

	// ---- sequencer state
	state_t    state_q, state_d;
	box_side_t side_q;

	// ---- command word held for the whole command
	op_t                     op_q;
	logic signed [POS_W-1:0] xa_q, ya_q, xb_q, yb_q;
	logic [PIX_W-1:0]        val_q;
	logic [R2_W-1:0]         r2_q;
	logic                    cmd_oob_q;

	// ---- scan window and cursor
	logic [COORD_W-1:0] x_lo_q, x_hi_q, y_lo_q, y_hi_q;
	logic [COORD_W-1:0] x_q, y_q;

	// ---- pixel stage feeding the RAM write port
	logic              v_s1;
	logic              disk_s1;
	logic [ADDR_W-1:0] addr_s1;
	logic [SQ_W-1:0]   dxsq_s1, dysq_s1;

	// ---- result registers
	logic             done_q;
	logic [PIX_W-1:0] read_value_q;
	logic             oob_q;

	// ---- combinational
	op_t                      op_in;
	logic                     accept;
	logic [SIZE_W-1:0]        eff_w, eff_h;
	logic signed [SPAN_W-1:0] eff_w_m1, eff_h_m1;
	logic                     inside_in;
	logic signed [POS_W-1:0]  raw_x_lo, raw_x_hi, raw_y_lo, raw_y_hi;
	logic signed [SPAN_W-1:0] x_lo_c, x_hi_c, y_lo_c, y_hi_c;
	logic signed [SPAN_W-1:0] raw_x_hi_w, raw_y_hi_w;
	logic                     span_ok;
	logic                     last_side;
	logic                     x_end, y_end;
	logic                     in_scan;
	logic [COORD_W-1:0]       feed_x, feed_y;
	logic                     feed_pix;
	logic [2*COORD_W-1:0]     addr_full;
	logic signed [SPAN_W-1:0] dx, dy;
	logic signed [2*SPAN_W-1:0] dx_prod, dy_prod;
	logic [2*RADIUS_W-1:0]    rsq;
	logic [SQ_W:0]            d2;
	logic                     ram_we;
	logic                     ram_rd_en;
	logic [PIX_W-1:0]         ram_rdata;

	assign op_in  = op_t'(operation);
	assign accept = start && (state_q == ST_IDLE);
	assign busy   = (state_q != ST_IDLE);

	// active size saturates at the store geometry
	assign eff_w    = (active_width_q  > SIZE_W'(MAX_WIDTH))  ? SIZE_W'(MAX_WIDTH)  : active_width_q;
	assign eff_h    = (active_height_q > SIZE_W'(MAX_HEIGHT)) ? SIZE_W'(MAX_HEIGHT) : active_height_q;
	assign eff_w_m1 = $signed({2'b00, eff_w}) - 9'sd1;
	assign eff_h_m1 = $signed({2'b00, eff_h}) - 9'sd1;

	assign inside_in = !x_a[POS_W-1] && !y_a[POS_W-1]
		&& (x_a[COORD_W-1:0] < eff_w) && (y_a[COORD_W-1:0] < eff_h);

	// unclipped rectangle for the current command and box side
	always_comb begin
		raw_x_lo = xa_q;
		raw_x_hi = xb_q;
		raw_y_lo = ya_q;
		raw_y_hi = yb_q;
		unique case (op_q)
			OP_FILL, OP_DISK: begin
				raw_x_lo = '0;
				raw_x_hi = POS_W'(MAX_WIDTH - 1);
				raw_y_lo = '0;
				raw_y_hi = POS_W'(MAX_HEIGHT - 1);
			end
			OP_HLINE: raw_y_hi = ya_q;
			OP_VLINE: raw_x_hi = xa_q;
			OP_BOX: begin
				unique case (side_q)
					SIDE_TOP:    raw_y_hi = ya_q;
					SIDE_BOTTOM: raw_y_lo = yb_q;
					SIDE_LEFT:   raw_x_hi = xa_q;
					SIDE_RIGHT:  raw_x_lo = xb_q;
				endcase
			end
			default: ;	// filled box takes the corners as given
		endcase
	end

	// clip to the active area
	assign raw_x_hi_w = $signed({raw_x_hi[POS_W-1], raw_x_hi});
	assign raw_y_hi_w = $signed({raw_y_hi[POS_W-1], raw_y_hi});
	assign x_lo_c = raw_x_lo[POS_W-1] ? '0 : $signed({1'b0, raw_x_lo});
	assign y_lo_c = raw_y_lo[POS_W-1] ? '0 : $signed({1'b0, raw_y_lo});
	assign x_hi_c = (raw_x_hi_w > eff_w_m1) ? eff_w_m1 : raw_x_hi_w;
	assign y_hi_c = (raw_y_hi_w > eff_h_m1) ? eff_h_m1 : raw_y_hi_w;
	assign span_ok = (x_lo_c <= x_hi_c) && (y_lo_c <= y_hi_c);

	assign last_side = (op_q != OP_BOX) || (side_q == SIDE_RIGHT);
	assign x_end     = (x_q == x_hi_q);
	assign y_end     = (y_q == y_hi_q);
	assign in_scan   = (state_q == ST_SCAN);

	// pixel source: the scan cursor, or the set/get coordinate at accept
	assign feed_x   = in_scan ? x_q : x_a[COORD_W-1:0];
	assign feed_y   = in_scan ? y_q : y_a[COORD_W-1:0];
	assign feed_pix = in_scan || (accept && (op_in == OP_SET) && inside_in);

	assign addr_full = {{COORD_W{1'b0}}, feed_y} * (2*COORD_W)'(MAX_WIDTH)
		+ {{COORD_W{1'b0}}, feed_x};

	// squared distance terms for the disk test, registered before the compare
	assign dx      = $signed({2'b00, feed_x}) - $signed({xa_q[POS_W-1], xa_q});
	assign dy      = $signed({2'b00, feed_y}) - $signed({ya_q[POS_W-1], ya_q});
	assign dx_prod = dx * dx;
	assign dy_prod = dy * dy;

	assign rsq = radius_q4 * radius_q4;

	assign d2     = {1'b0, dxsq_s1} + {1'b0, dysq_s1};
	assign ram_we = v_s1 && (!disk_s1 || (d2 <= {{(SQ_W + 1 - R2_W){1'b0}}, r2_q}));

	assign ram_rd_en = accept && (op_in == OP_GET);

	// ---- next state
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			ST_IDLE: begin
				if (accept) begin
					priority if (op_in == OP_SET) begin
						state_d = ST_DRAIN;
					end else if (op_in == OP_GET) begin
						state_d = ST_GET_READ;
					end else begin
						state_d = ST_SETUP;
					end
				end
			end
			ST_SETUP: begin
				priority if (span_ok) begin
					state_d = ST_SCAN;
				end else if (last_side) begin
					state_d = ST_DRAIN;
				end else begin
					state_d = ST_SETUP;
				end
			end
			ST_SCAN: begin
				if (x_end && y_end) begin
					state_d = last_side ? ST_DRAIN : ST_SETUP;
				end
			end
			ST_DRAIN:    state_d = ST_IDLE;
			ST_GET_READ: state_d = ST_IDLE;
			default:     state_d = ST_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	// ---- config port
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			active_width_q  <= SIZE_W'(64);
			active_height_q <= SIZE_W'(64);
			background_q    <= '0;
		end else if (cfg_write) begin
			unique case (reg_idx_t'(cfg_index))
				REG_ACTIVE_WIDTH:  active_width_q  <= cfg_data[SIZE_W-1:0];
				REG_ACTIVE_HEIGHT: active_height_q <= cfg_data[SIZE_W-1:0];
				REG_BACKGROUND:    background_q    <= cfg_data;
				default: ;	// unknown index ignored
			endcase
		end
	end

	// ---- command capture, window and cursor
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			side_q <= SIDE_TOP;
		end else if (accept) begin
			side_q <= SIDE_TOP;
		end else if (!last_side && (((state_q == ST_SETUP) && !span_ok)
				|| (in_scan && x_end && y_end))) begin
			side_q <= box_side_t'(side_q + 2'd1);
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			op_q      <= op_in;
			xa_q      <= x_a;
			ya_q      <= y_a;
			xb_q      <= x_b;
			yb_q      <= y_b;
			val_q     <= pixel_value;
			r2_q      <= rsq[2*RADIUS_W-1:2*RADIUS_W-R2_W];
			cmd_oob_q <= ((op_in == OP_SET) || (op_in == OP_GET)) && !inside_in;
		end
		if ((state_q == ST_SETUP) && span_ok) begin
			x_lo_q <= x_lo_c[COORD_W-1:0];
			x_hi_q <= x_hi_c[COORD_W-1:0];
			y_lo_q <= y_lo_c[COORD_W-1:0];
			y_hi_q <= y_hi_c[COORD_W-1:0];
			x_q    <= x_lo_c[COORD_W-1:0];
			y_q    <= y_lo_c[COORD_W-1:0];
		end else if (in_scan) begin
			if (x_end) begin
				x_q <= x_lo_q;
				y_q <= y_q + 1'b1;
			end else begin
				x_q <= x_q + 1'b1;
			end
		end
	end

	// ---- pixel stage
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
		end else begin
			v_s1 <= feed_pix;
		end
	end

	always_ff @(posedge clk) begin
		disk_s1 <= in_scan && (op_q == OP_DISK);
		addr_s1 <= addr_full[ADDR_W-1:0];
		dxsq_s1 <= dx_prod[SQ_W-1:0];
		dysq_s1 <= dy_prod[SQ_W-1:0];
	end

	crde_ram #(
		.WIDTH (PIX_W),
		.DEPTH (STORE_DEPTH)
	) u_frame_store (
		.clk     (clk),
		.we      (ram_we),
		.wr_addr (addr_s1),
		.wr_data (val_q),
		.rd_en   (ram_rd_en),
		.rd_addr (addr_full[ADDR_W-1:0]),
		.rd_data (ram_rdata)
	);

	// ---- result word: one strobe per command, after the last write lands
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			done_q <= 1'b0;
		end else begin
			done_q <= (state_q == ST_DRAIN) || (state_q == ST_GET_READ);
		end
	end

	always_ff @(posedge clk) begin
		if (state_q == ST_DRAIN) begin
			read_value_q <= '0;
			oob_q        <= cmd_oob_q;
		end else if (state_q == ST_GET_READ) begin
			read_value_q <= cmd_oob_q ? background_q : ram_rdata;
			oob_q        <= cmd_oob_q;
		end
	end

	assign done          = done_q;
	assign read_value    = read_value_q;
	assign out_of_bounds = oob_q;

endmodule

>>> rtl/core/crde_checker.sv
module crde_checker (
	input logic clk,
	input logic arst_n,
	input logic start,
	input logic busy,
	input logic done
);

	// result word only once the engine has gone idle
	a_done_idle: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> !busy)
		else $error("done while busy");

	a_accept_busy: assert property (@(posedge clk) disable iff (!arst_n)
		start && !busy |=> busy)
		else $error("accepted command did not raise busy");

	a_done_pulse: assert property (@(posedge clk) disable iff (!arst_n)
		done |=> !done)
		else $error("done held for more than one cycle");

	// every command completion reports exactly then
	a_finish_done: assert property (@(posedge clk) disable iff (!arst_n)
		$fell(busy) |-> done)
		else $error("command finished without a result word");

endmodule

bind char_raster_draw_engine crde_checker u_crde_checker (
	.clk    (clk),
	.arst_n (arst_n),
	.start  (start),
	.busy   (busy),
	.done   (done)
);

>>> tb/tb_char_raster_draw_engine.sv
`timescale 1ns / 100ps

module tb_char_raster_draw_engine;

	import crde_pkg::*;

	localparam int FB_COLS = MAX_WIDTH_DEF;
	localparam int FB_ROWS = MAX_HEIGHT_DEF;
	// index 3 is not a register: writes to it must change nothing
	localparam logic [CFG_IDX_W-1:0] REG_UNUSED = 2'd3;

	// one row of stimulus: a command word or a register write
	typedef enum bit {ROW_DRAW, ROW_REG} row_kind_t;

	typedef struct {
		row_kind_t               kind;
		op_t                     op;
		logic signed [POS_W-1:0] xa, ya, xb, yb;
		logic [PIX_W-1:0]        pix;
		logic [RADIUS_W-1:0]     rq;
		bit                      known;     // expected reply typed into the row
		logic [PIX_W-1:0]        want_rd;
		logic                    want_oob;
		logic [CFG_IDX_W-1:0]    reg_idx;
		logic [CFG_DATA_W-1:0]   reg_val;
	} draw_row_t;

	// what one done strobe carries
	typedef struct {
		logic [PIX_W-1:0] rd;
		logic             oob;
	} draw_reply_t;

	logic                    clk;
	logic                    arst_n = 1'b0;
	logic                    start = 1'b0;
	logic                    busy;
	logic [2:0]              operation = 3'd0;
	logic signed [POS_W-1:0] x_a = '0;
	logic signed [POS_W-1:0] y_a = '0;
	logic signed [POS_W-1:0] x_b = '0;
	logic signed [POS_W-1:0] y_b = '0;
	logic [PIX_W-1:0]        pixel_value = '0;
	logic [RADIUS_W-1:0]     radius_q4 = '0;
	logic                    cfg_write = 1'b0;
	logic [CFG_IDX_W-1:0]    cfg_index = '0;
	logic [CFG_DATA_W-1:0]   cfg_data = '0;
	logic                    done;
	logic [PIX_W-1:0]        read_value;
	logic                    out_of_bounds;

	// shadow copy of the frame store and the registers
	logic [PIX_W-1:0]  pixel_mem [STORE_DEPTH];
	logic [SIZE_W-1:0] act_cols = 7'd64;
	logic [SIZE_W-1:0] act_rows = 7'd64;
	logic [PIX_W-1:0]  bg_char = 8'd0;

	draw_reply_t reply_q[$];       // replies still owed by the engine
	draw_row_t   directed_rows[$];
	int          mismatch_count = 0;
	bit          allow_gaps = 1'b1;

	char_raster_draw_engine uut (
		.clk           (clk),
		.arst_n        (arst_n),
		.start         (start),
		.busy          (busy),
		.operation     (operation),
		.x_a           (x_a),
		.y_a           (y_a),
		.x_b           (x_b),
		.y_b           (y_b),
		.pixel_value   (pixel_value),
		.radius_q4     (radius_q4),
		.cfg_write     (cfg_write),
		.cfg_index     (cfg_index),
		.cfg_data      (cfg_data),
		.done          (done),
		.read_value    (read_value),
		.out_of_bounds (out_of_bounds)
	);

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	// hard stop, several times the slowest legal run (every word a full 64x64 scan)
	initial begin
		#40_000_000;
		$display("CHECK FAILED");
		$finish;
	end

	// ---------------------------------------------------------------- shadow model

	// sizes above the store saturate; zero leaves nothing in use
	function automatic int eff_cols();
		return (act_cols > FB_COLS) ? FB_COLS : int'(act_cols);
	endfunction

	function automatic int eff_rows();
		return (act_rows > FB_ROWS) ? FB_ROWS : int'(act_rows);
	endfunction

	function automatic bit in_area(input int x, input int y);
		return x >= 0 && y >= 0 && x < eff_cols() && y < eff_rows();
	endfunction

	// clipped rectangle; a reversed range simply leaves the loop empty
	function automatic void paint_rect(input int x1, input int y1, input int x2,
			input int y2, input logic [PIX_W-1:0] v);
		if (x1 < 0) x1 = 0;
		if (y1 < 0) y1 = 0;
		if (x2 > eff_cols() - 1) x2 = eff_cols() - 1;
		if (y2 > eff_rows() - 1) y2 = eff_rows() - 1;
		for (int y = y1; y <= y2; y++)
			for (int x = x1; x <= x2; x++)
				pixel_mem[y * FB_COLS + x] = v;
	endfunction

	// disk: squared distance against floor(r*r), r in Q7.4
	function automatic void paint_disk(input int cx, input int cy,
			input logic [RADIUS_W-1:0] rq, input logic [PIX_W-1:0] v);
		int r2;
		int d2;
		r2 = (int'(rq) * int'(rq)) >>> 8;
		for (int y = 0; y < eff_rows(); y++)
			for (int x = 0; x < eff_cols(); x++) begin
				d2 = (x - cx) * (x - cx) + (y - cy) * (y - cy);
				if (d2 <= r2)
					pixel_mem[y * FB_COLS + x] = v;
			end
	endfunction

	// applies one command word to the shadow store and returns its reply
	function automatic draw_reply_t render_cmd(input draw_row_t c);
		draw_reply_t rep;
		int ax, ay, bx, by;
		ax = c.xa;
		ay = c.ya;
		bx = c.xb;
		by = c.yb;
		rep.rd = '0;
		rep.oob = 1'b0;
		case (c.op)
			OP_FILL: paint_rect(0, 0, FB_COLS - 1, FB_ROWS - 1, c.pix);
			OP_SET: begin
				if (in_area(ax, ay)) pixel_mem[ay * FB_COLS + ax] = c.pix;
				else rep.oob = 1'b1;
			end
			OP_GET: begin
				if (in_area(ax, ay)) begin
					rep.rd = pixel_mem[ay * FB_COLS + ax];
				end else begin
					rep.rd = bg_char;
					rep.oob = 1'b1;
				end
			end
			OP_HLINE: paint_rect(ax, ay, bx, ay, c.pix);
			OP_VLINE: paint_rect(ax, ay, ax, by, c.pix);
			OP_BOX: begin
				paint_rect(ax, ay, bx, ay, c.pix);
				paint_rect(ax, by, bx, by, c.pix);
				paint_rect(ax, ay, ax, by, c.pix);
				paint_rect(bx, ay, bx, by, c.pix);
			end
			OP_FILLED_BOX: paint_rect(ax, ay, bx, by, c.pix);
			OP_DISK: paint_disk(ax, ay, c.rq, c.pix);
			default: ;
		endcase
		return rep;
	endfunction

	// ---------------------------------------------------------------- stimulus rows

	function automatic draw_row_t cmd_row(input op_t op, input int xa, input int ya,
			input int xb, input int yb, input int pix, input int rq,
			input bit known, input int rd, input bit oob);
		draw_row_t r;
		r.kind = ROW_DRAW;
		r.op = op;
		r.xa = xa[POS_W-1:0];
		r.ya = ya[POS_W-1:0];
		r.xb = xb[POS_W-1:0];
		r.yb = yb[POS_W-1:0];
		r.pix = pix[PIX_W-1:0];
		r.rq = rq[RADIUS_W-1:0];
		r.known = known;
		r.want_rd = rd[PIX_W-1:0];
		r.want_oob = oob;
		r.reg_idx = '0;
		r.reg_val = '0;
		return r;
	endfunction

	function automatic draw_row_t reg_row(input logic [CFG_IDX_W-1:0] idx,
			input int val);
		draw_row_t r;
		r = cmd_row(OP_FILL, 0, 0, 0, 0, 0, 0, 1'b0, 0, 1'b0);
		r.kind = ROW_REG;
		r.reg_idx = idx;
		r.reg_val = val[CFG_DATA_W-1:0];
		return r;
	endfunction

	// mostly near the active area, now and then anywhere in the signed range
	function automatic logic [POS_W-1:0] pick_pos(input int span);
		int p;
		if ($urandom_range(0, 3) == 0)
			return POS_W'($urandom_range(0, 255));
		p = int'($urandom_range(0, span + 5)) - 3;
		return p[POS_W-1:0];
	endfunction

	function automatic draw_row_t random_draw();
		draw_row_t r;
		r = cmd_row(op_t'($urandom_range(0, 7)), 0, 0, 0, 0, 0, 0, 1'b0, 0, 1'b0);
		r.xa = pick_pos(eff_cols());
		r.ya = pick_pos(eff_rows());
		r.xb = pick_pos(eff_cols());
		r.yb = pick_pos(eff_rows());
		r.pix = PIX_W'($urandom_range(0, 255));
		// small radii most of the time, the full 11 bits now and then
		r.rq = ($urandom_range(0, 2) == 0) ? RADIUS_W'($urandom_range(0, 2047))
			: RADIUS_W'($urandom_range(0, 160));
		return r;
	endfunction

	// ---------------------------------------------------------------- driving

	// waits until every reply is in, then lets the engine settle
	task automatic wait_drained();
		while (reply_q.size() != 0) @(posedge clk);
		repeat (4) @(posedge clk);
	endtask

	// register writes only while idle
	task automatic write_reg(input logic [CFG_IDX_W-1:0] idx,
			input logic [CFG_DATA_W-1:0] val);
		start <= 1'b0;
		wait_drained();
		cfg_write <= 1'b1;
		cfg_index <= idx;
		cfg_data <= val;
		@(posedge clk);
		cfg_write <= 1'b0;
		case (idx)
			REG_ACTIVE_WIDTH:  act_cols = val[SIZE_W-1:0];
			REG_ACTIVE_HEIGHT: act_rows = val[SIZE_W-1:0];
			REG_BACKGROUND:    bg_char = val;
			default: ;
		endcase
	endtask

	// start stays high from one word to the next unless a gap is drawn, so it
	// never gets two assignments in one step
	task automatic send_cmd(input draw_row_t r);
		draw_reply_t rep;
		if (allow_gaps && $urandom_range(0, 99) < 17) begin
			start <= 1'b0;
			repeat ($urandom_range(1, 8)) @(posedge clk);
		end
		start <= 1'b1;
		operation <= r.op;
		x_a <= r.xa;
		y_a <= r.ya;
		x_b <= r.xb;
		y_b <= r.yb;
		pixel_value <= r.pix;
		radius_q4 <= r.rq;
		// word taken at the first edge with busy low
		do @(posedge clk); while (busy);
		rep = render_cmd(r);
		if (r.known) begin
			rep.rd = r.want_rd;
			rep.oob = r.want_oob;
		end
		reply_q.push_back(rep);
	endtask

	// ---------------------------------------------------------------- checking

	task automatic note_mismatch(input string what, input logic [PIX_W-1:0] want_v,
			input logic [PIX_W-1:0] got_v);
		mismatch_count++;
		if (mismatch_count <= 10)
			$display("mismatch at %0t on %s: expected %h, got %h", $time, what, want_v,
				got_v);
	endtask

	// results cannot be held off, so every done cycle is taken as it comes
	always @(posedge clk) begin
		draw_reply_t want;
		if (arst_n && done === 1'b1) begin
			if (reply_q.size() == 0) begin
				note_mismatch("unexpected done", '0, read_value);
			end else begin
				want = reply_q.pop_front();
				if (read_value !== want.rd)
					note_mismatch("read_value", want.rd, read_value);
				if (out_of_bounds !== want.oob)
					note_mismatch("out_of_bounds", PIX_W'(want.oob),
						PIX_W'(out_of_bounds));
			end
		end
	end

	// ---------------------------------------------------------------- sequence

	initial begin
		logic [CFG_DATA_W-1:0] wr, hr, bgv;
		int n_items;

		// directed rows; known replies only where they are obvious
		// out-of-bounds get straight after reset: background is still zero
		directed_rows.push_back(cmd_row(OP_GET, -128, -128, 0, 0, 0, 0, 1'b1, 0, 1'b1));
		// whole store written before any in-bounds read
		directed_rows.push_back(cmd_row(OP_FILL, 0, 0, 0, 0, 'hA5, 0, 1'b0, 0, 1'b0));
		directed_rows.push_back(cmd_row(OP_GET, 0, 0, 0, 0, 0, 0, 1'b1, 'hA5, 1'b0));
		directed_rows.push_back(cmd_row(OP_GET, 63, 63, 0, 0, 0, 0, 1'b1, 'hA5, 1'b0));
		directed_rows.push_back(cmd_row(OP_GET, 64, 0, 0, 0, 0, 0, 1'b1, 0, 1'b1));
		directed_rows.push_back(cmd_row(OP_SET, 127, 127, 0, 0, 'hFF, 0, 1'b1, 0, 1'b1));
		directed_rows.push_back(cmd_row(OP_SET, 0, 63, 0, 0, 'h5A, 0, 1'b1, 0, 1'b0));
		directed_rows.push_back(cmd_row(OP_GET, 0, 63, 0, 0, 0, 0, 1'b1, 'h5A, 1'b0));
		directed_rows.push_back(cmd_row(OP_SET, -1, 5, 0, 0, 'h00, 0, 1'b1, 0, 1'b1));
		// lines clipped at both ends, reversed, and with the fixed row off screen
		directed_rows.push_back(cmd_row(OP_HLINE, -128, 3, 127, 0, 'h11, 0, 1'b0, 0, 1'b0));
		directed_rows.push_back(cmd_row(OP_VLINE, 5, -128, 0, 127, 'h22, 0, 1'b0, 0, 1'b0));
		directed_rows.push_back(cmd_row(OP_HLINE, 10, 4, 2, 0, 'h99, 0, 1'b0, 0, 1'b0));
		directed_rows.push_back(cmd_row(OP_HLINE, 0, 70, 63, 0, 'h98, 0, 1'b0, 0, 1'b0));
		// outline, then one reversed in x: only the two side edges survive
		directed_rows.push_back(cmd_row(OP_BOX, 2, 2, 9, 7, 'h33, 0, 1'b0, 0, 1'b0));
		directed_rows.push_back(cmd_row(OP_BOX, 9, 2, 2, 7, 'h3C, 0, 1'b0, 0, 1'b0));
		directed_rows.push_back(cmd_row(OP_FILLED_BOX, -5, -5, 127, 127, 'h44, 0,
			1'b0, 0, 1'b0));
		// disks: zero radius, radius under one, a radius of 5.5, the largest
		directed_rows.push_back(cmd_row(OP_DISK, 10, 10, 0, 0, 'h55, 0, 1'b0, 0, 1'b0));
		directed_rows.push_back(cmd_row(OP_DISK, 31, 31, 0, 0, 'h66, 15, 1'b0, 0, 1'b0));
		directed_rows.push_back(cmd_row(OP_DISK, 20, 20, 0, 0, 'h77, 88, 1'b0, 0, 1'b0));
		directed_rows.push_back(cmd_row(OP_DISK, -128, 127, 0, 0, 'h88, 2047,
			1'b0, 0, 1'b0));
		directed_rows.push_back(cmd_row(OP_GET, 20, 25, 0, 0, 0, 0, 1'b0, 0, 1'b0));
		// zero width: everything is out of bounds and fill paints nothing
		directed_rows.push_back(reg_row(REG_BACKGROUND, 'hC3));
		directed_rows.push_back(reg_row(REG_ACTIVE_WIDTH, 0));
		directed_rows.push_back(cmd_row(OP_GET, 0, 0, 0, 0, 0, 0, 1'b1, 'hC3, 1'b1));
		directed_rows.push_back(cmd_row(OP_SET, 0, 0, 0, 0, 'h12, 0, 1'b1, 0, 1'b1));
		directed_rows.push_back(cmd_row(OP_FILL, 0, 0, 0, 0, 'h00, 0, 1'b0, 0, 1'b0));
		// oversized width saturates, single row
		directed_rows.push_back(reg_row(REG_ACTIVE_WIDTH, 'hFF));
		directed_rows.push_back(reg_row(REG_ACTIVE_HEIGHT, 1));
		directed_rows.push_back(cmd_row(OP_GET, 63, 0, 0, 0, 0, 0, 1'b0, 0, 1'b0));
		directed_rows.push_back(cmd_row(OP_GET, 0, 1, 0, 0, 0, 0, 1'b1, 'hC3, 1'b1));
		// write to the spare index, then back to full size: pixels did not move
		directed_rows.push_back(reg_row(REG_UNUSED, 'h5A));
		directed_rows.push_back(reg_row(REG_ACTIVE_WIDTH, 64));
		directed_rows.push_back(reg_row(REG_ACTIVE_HEIGHT, 64));
		directed_rows.push_back(cmd_row(OP_GET, 0, 0, 0, 0, 0, 0, 1'b0, 0, 1'b0));
		directed_rows.push_back(cmd_row(OP_GET, 10, 10, 0, 0, 0, 0, 1'b0, 0, 1'b0));

		repeat (12) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		foreach (directed_rows[k]) begin
			if (directed_rows[k].kind == ROW_REG)
				write_reg(directed_rows[k].reg_idx, directed_rows[k].reg_val);
			else
				send_cmd(directed_rows[k]);
		end

		// random phases, each with its own geometry; mostly small areas so
		// that fills and disks stay short
		for (int p = 0; p < 7; p++) begin
			bgv = CFG_DATA_W'($urandom_range(0, 255));
			case (p)
				0: begin wr = 8'd64; hr = 8'd64; end
				1: begin wr = 8'd1; hr = 8'd1; bgv = 8'hFF; end
				2: begin
					wr = CFG_DATA_W'($urandom_range(2, 16));
					hr = CFG_DATA_W'($urandom_range(2, 16));
				end
				3: begin wr = 8'hFF; hr = CFG_DATA_W'($urandom_range(1, 20)); end
				4: begin wr = CFG_DATA_W'($urandom_range(1, 20)); hr = 8'd0; end
				5: begin
					wr = CFG_DATA_W'($urandom_range(0, 255));
					hr = CFG_DATA_W'($urandom_range(1, 12));
				end
				default: begin
					wr = CFG_DATA_W'($urandom_range(3, 24));
					hr = CFG_DATA_W'($urandom_range(3, 24));
				end
			endcase
			write_reg(REG_ACTIVE_WIDTH, wr);
			write_reg(REG_ACTIVE_HEIGHT, hr);
			write_reg(REG_BACKGROUND, bgv);
			write_reg(REG_UNUSED, CFG_DATA_W'($urandom_range(0, 255)));
			// one phase runs back to back with no gaps at all
			allow_gaps = (p != 2);
			// zero-height phase is only noise, keep it short
			n_items = (p == 4) ? 8 : 17;
			for (int i = 0; i < n_items; i++) begin
				// sender holds off once until the engine has answered everything
				if (p == 5 && i == 8) begin
					start <= 1'b0;
					wait_drained();
				end
				send_cmd(random_draw());
			end
		end

		start <= 1'b0;
		wait_drained();
		repeat (16) @(posedge clk);
		if (mismatch_count == 0 && reply_q.size() == 0) begin
			$display("CHECK OK");
		end else begin
			$display("CHECK FAILED");
		end
		$finish;
	end

endmodule

>>> sim.f
rtl/core/crde_pkg.sv
rtl/core/crde_ram.sv
rtl/core/char_raster_draw_engine.sv
rtl/core/crde_checker.sv
tb/tb_char_raster_draw_engine.sv
